// ===== sv/swrt_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and control structs of the request throttler
package swrt_pkg;

    localparam int TIME_W     = 48;
    localparam int CNT_W      = 6;
    localparam int PERIOD_W   = 20;
    localparam int THR_W      = 17;
    localparam int QLIM_W     = 6;
    localparam int WB_W       = 6;
    localparam int WLIM_W     = 5;
    localparam int RND_W      = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int QUEUE_DEPTH_DEF  = 32;
    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF     = 16;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TIMER   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMER   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QLIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WBATCH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WLIMIT  = 3'd6;

    typedef logic [2:0] emit_sel_t;
    localparam emit_sel_t EMIT_PASS    = 3'd0;
    localparam emit_sel_t EMIT_VERDICT = 3'd1;
    localparam emit_sel_t EMIT_EVICT   = 3'd2;
    localparam emit_sel_t EMIT_RELEASE = 3'd3;
    localparam emit_sel_t EMIT_IDLE    = 3'd4;
    localparam emit_sel_t EMIT_EXPIRY  = 3'd5;

    typedef struct packed {
        logic      latch_in;
        logic      q_rd;
        logic      q_push;
        logic      q_pop;
        logic      w_rd;
        logic      w_push;
        logic      w_pop;
        logic      n_clear;
        logic      n_one;
        logic      acc_init;
        logic      acc_step;
        logic      latch_t0;
        logic      exp_mul;
        logic      emit;
        emit_sel_t emit_sel;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic enable;
        logic q_full;
        logic leak;
        logic q_empty;
        logic w_short;
        logic w_full;
        logic w_over;
        logic rel_ok;
        logic n_zero;
        logic out_free;
    } status_t;

endpackage

// ===== sv/swrt_if.sv =====
`timescale 1ns / 1ps
// request and result channel interfaces
interface swrt_req_if #(
    parameter int TAG_W = swrt_pkg::TAG_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [TAG_W-1:0]             request_tag;
    logic [swrt_pkg::TIME_W-1:0]  now_us;
    logic [swrt_pkg::RND_W-1:0]   random_value;

    modport source (output valid, operation, request_tag, now_us, random_value,
                    input ready);
    modport sink   (input valid, operation, request_tag, now_us, random_value,
                    output ready);
endinterface

interface swrt_res_if #(
    parameter int TAG_W = swrt_pkg::TAG_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [swrt_pkg::KIND_W-1:0]  kind;
    logic [TAG_W-1:0]             tag;
    logic                         dropped;
    logic                         evicted;
    logic [TAG_W-1:0]             evicted_tag;
    logic [swrt_pkg::TIME_W-1:0]  next_expire_us;
    logic                         last;

    modport source (output valid, kind, tag, dropped, evicted, evicted_tag,
                    next_expire_us, last, input ready);
    modport sink   (input valid, kind, tag, dropped, evicted, evicted_tag,
                    next_expire_us, last, output ready);
endinterface

// ===== sv/sliding_window_request_throttler.sv =====
`timescale 1ns / 1ps
// top level of the sliding window request throttler
//
// req carries one request or timer event, res returns results with valid/ready;
// an event is taken when req.valid and req.ready are both high.
// a request gives one result: a verdict, or an immediate release when disabled.
// a timer event releases queued requests while the window allows and ends
// with one result carrying the next timer time; last marks the final result.
// configuration is written through cfg_we, cfg_index and cfg_data while idle;
// the user is bound to this, the block itself does not enforce it.
// a verdict, a pass-through release or an empty-queue timer result goes into
// the output register from the dispatch state; an eviction or a short-window
// release first reads the queue ram; a long-window timer event reads the oldest
// window entry, releases queued requests one by one while allowed, records any
// release in the window, dropping old entries, and computes the next timer time.
// req.ready is high only while the sequencer is idle, so the next event is
// taken in the cycle after the final result is loaded; a stall on res holds
// the sequencer in place. reset empties the queue and the window, restores
// the configuration defaults and clears the result valid flag.
module sliding_window_request_throttler #(
    parameter int QUEUE_DEPTH  = swrt_pkg::QUEUE_DEPTH_DEF,
    parameter int WINDOW_DEPTH = swrt_pkg::WINDOW_DEPTH_DEF,
    parameter int TAG_BITS     = swrt_pkg::TAG_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [swrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swrt_pkg::CFG_DATA_W-1:0] cfg_data,
    swrt_req_if.sink                        req,
    swrt_res_if.source                      res
);

    swrt_pkg::cmd_t    cmd;
    swrt_pkg::status_t sts;
    logic              in_ready;

    assign req.ready = in_ready;

    swrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swrt_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TAG_W        (TAG_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_operation       (req.operation),
        .in_request_tag     (req.request_tag),
        .in_now_us          (req.now_us),
        .in_random_value    (req.random_value),
        .cmd                (cmd),
        .sts                (sts),
        .out_ready          (res.ready),
        .out_valid          (res.valid),
        .out_kind           (res.kind),
        .out_tag            (res.tag),
        .out_dropped        (res.dropped),
        .out_evicted        (res.evicted),
        .out_evicted_tag    (res.evicted_tag),
        .out_next_expire_us (res.next_expire_us),
        .out_last           (res.last)
    );

endmodule

// ===== sv/swrt_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module swrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/swrt_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine of the request throttler
module swrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swrt_pkg::status_t sts,
    output swrt_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_EVICT   = 4'd2;
    localparam logic [3:0] S_SREL    = 4'd3;
    localparam logic [3:0] S_STIMER  = 4'd4;
    localparam logic [3:0] S_LT0     = 4'd5;
    localparam logic [3:0] S_LCHK    = 4'd6;
    localparam logic [3:0] S_LREL    = 4'd7;
    localparam logic [3:0] S_LPUSH   = 4'd8;
    localparam logic [3:0] S_LPREPOP = 4'd9;
    localparam logic [3:0] S_LTRIM   = 4'd10;
    localparam logic [3:0] S_LTPOP   = 4'd11;
    localparam logic [3:0] S_LEXP0   = 4'd12;
    localparam logic [3:0] S_LEXP1   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.op == swrt_pkg::OP_REQUEST)
                begin
                    if (!sts.enable)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = swrt_pkg::EMIT_PASS;
                            cmd.last     = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    else if (sts.q_full && sts.leak)
                    begin
                        cmd.q_rd   = 1'b1;
                        state_next = S_EVICT;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = swrt_pkg::EMIT_VERDICT;
                        cmd.last     = 1'b1;
                        cmd.q_push   = !sts.q_full;
                        state_next   = S_IDLE;
                    end
                end
                else if (sts.q_empty)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = swrt_pkg::EMIT_IDLE;
                        cmd.last     = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (sts.w_short)
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_SREL;
                end
                else
                begin
                    cmd.w_rd     = 1'b1;
                    cmd.n_clear  = 1'b1;
                    cmd.acc_init = 1'b1;
                    state_next   = S_LT0;
                end
            end
            S_EVICT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = swrt_pkg::EMIT_EVICT;
                    cmd.last     = 1'b1;
                    cmd.q_pop    = 1'b1;
                    cmd.q_push   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SREL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = swrt_pkg::EMIT_RELEASE;
                    cmd.q_pop    = 1'b1;
                    cmd.n_one    = 1'b1;
                    state_next   = S_STIMER;
                end
            end
            S_STIMER:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = swrt_pkg::EMIT_IDLE;
                    cmd.last     = 1'b1;
                    cmd.w_push   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LT0:
            begin
                cmd.latch_t0 = 1'b1;
                state_next   = S_LCHK;
            end
            S_LCHK:
            begin
                if (sts.rel_ok)
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = S_LREL;
                end
                else if (sts.n_zero)
                begin
                    state_next = S_LEXP0;
                end
                else
                begin
                    state_next = S_LPUSH;
                end
            end
            S_LREL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = swrt_pkg::EMIT_RELEASE;
                    cmd.q_pop    = 1'b1;
                    cmd.acc_step = 1'b1;
                    state_next   = S_LCHK;
                end
            end
            S_LPUSH:
            begin
                if (sts.w_full)
                begin
                    cmd.w_rd   = 1'b1;
                    state_next = S_LPREPOP;
                end
                else
                begin
                    cmd.w_push = 1'b1;
                    state_next = S_LTRIM;
                end
            end
            S_LPREPOP:
            begin
                cmd.w_pop  = 1'b1;
                state_next = S_LPUSH;
            end
            S_LTRIM:
            begin
                if (sts.w_over)
                begin
                    cmd.w_rd   = 1'b1;
                    state_next = S_LTPOP;
                end
                else
                begin
                    state_next = S_LEXP0;
                end
            end
            S_LTPOP:
            begin
                cmd.w_pop  = 1'b1;
                state_next = S_LTRIM;
            end
            S_LEXP0:
            begin
                cmd.w_rd    = 1'b1;
                cmd.exp_mul = 1'b1;
                state_next  = S_LEXP1;
            end
            S_LEXP1:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = swrt_pkg::EMIT_EXPIRY;
                    cmd.last     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/swrt_dp.sv =====
`timescale 1ns / 1ps
// datapath: configuration, request queue, release window and result register
module swrt_dp #(
    parameter int QUEUE_DEPTH  = swrt_pkg::QUEUE_DEPTH_DEF,
    parameter int WINDOW_DEPTH = swrt_pkg::WINDOW_DEPTH_DEF,
    parameter int TAG_W        = swrt_pkg::TAG_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [swrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swrt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_operation,
    input  logic [TAG_W-1:0]                  in_request_tag,
    input  logic [swrt_pkg::TIME_W-1:0]       in_now_us,
    input  logic [swrt_pkg::RND_W-1:0]        in_random_value,
    input  swrt_pkg::cmd_t                    cmd,
    output swrt_pkg::status_t                 sts,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [swrt_pkg::KIND_W-1:0]       out_kind,
    output logic [TAG_W-1:0]                  out_tag,
    output logic                              out_dropped,
    output logic                              out_evicted,
    output logic [TAG_W-1:0]                  out_evicted_tag,
    output logic [swrt_pkg::TIME_W-1:0]       out_next_expire_us,
    output logic                              out_last
);

    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WA_W  = $clog2(WINDOW_DEPTH);
    localparam int WS_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int TOT_W = $clog2(WINDOW_DEPTH * 63 + 1);
    localparam int ACC_W = $clog2(WINDOW_DEPTH * 63 + QUEUE_DEPTH + 2) + swrt_pkg::PERIOD_W;
    localparam int EXP_W = $clog2(WINDOW_DEPTH + 64) + swrt_pkg::PERIOD_W;
    localparam int WR_W  = swrt_pkg::TIME_W + swrt_pkg::CNT_W;
    localparam int TW    = swrt_pkg::TIME_W;
    localparam int CW    = swrt_pkg::CNT_W;

    logic                            enable_reg;
    logic [swrt_pkg::PERIOD_W-1:0]   period_reg;
    logic [swrt_pkg::THR_W-1:0]      leak_reg;
    logic [swrt_pkg::QLIM_W-1:0]     qlimit_reg;
    logic [swrt_pkg::PERIOD_W-1:0]   idle_reg;
    logic [swrt_pkg::WB_W-1:0]       wbatch_reg;
    logic [swrt_pkg::WLIM_W-1:0]     wlimit_reg;

    logic                            op_reg;
    logic [TAG_W-1:0]                tag_reg;
    logic [TW-1:0]                   now_reg;
    logic [swrt_pkg::RND_W-1:0]      rnd_reg;

    logic [QA_W-1:0]  q_head_reg;
    logic [QA_W-1:0]  q_head_next;
    logic [QC_W-1:0]  q_count_reg;
    logic [QC_W-1:0]  q_count_next;
    logic [QA_W:0]    q_tail_sum;
    logic [QA_W-1:0]  q_tail;
    logic [TAG_W-1:0] q_rdata;

    logic [WA_W-1:0]  w_head_reg;
    logic [WS_W-1:0]  w_size_reg;
    logic [WA_W:0]    w_tail_sum;
    logic [WA_W-1:0]  w_tail;
    logic [WR_W-1:0]  w_rdata;
    logic [TW-1:0]    w_rd_time;
    logic [CW-1:0]    w_rd_cnt;
    logic [TOT_W-1:0] total_reg;
    logic [CW-1:0]    n_reg;

    logic [ACC_W-1:0] acc_reg;
    logic [TW-1:0]    elapsed_reg;
    logic             ge_reg;
    logic [EXP_W-1:0] exp_reg;

    logic [QC_W-1:0]  q_lim;
    logic [WS_W-1:0]  w_lim;

    assign w_rd_time = w_rdata[WR_W-1:CW];
    assign w_rd_cnt  = w_rdata[CW-1:0];

    // clamped limits
    always_comb
    begin
        if (qlimit_reg == '0)
        begin
            q_lim = QC_W'(1);
        end
        else if (32'(qlimit_reg) > QUEUE_DEPTH)
        begin
            q_lim = QC_W'(QUEUE_DEPTH);
        end
        else
        begin
            q_lim = QC_W'(qlimit_reg);
        end
        if (wlimit_reg == '0)
        begin
            w_lim = WS_W'(1);
        end
        else if (32'(wlimit_reg) > WINDOW_DEPTH)
        begin
            w_lim = WS_W'(WINDOW_DEPTH);
        end
        else
        begin
            w_lim = WS_W'(wlimit_reg);
        end
    end

    assign q_tail_sum = (QA_W + 1)'(q_head_reg) + (QA_W + 1)'(q_count_reg);
    assign q_tail = (32'(q_tail_sum) >= QUEUE_DEPTH)
                  ? QA_W'(q_tail_sum - (QA_W + 1)'(QUEUE_DEPTH)) : QA_W'(q_tail_sum);
    assign w_tail_sum = (WA_W + 1)'(w_head_reg) + (WA_W + 1)'(w_size_reg);
    assign w_tail = (32'(w_tail_sum) >= WINDOW_DEPTH)
                  ? WA_W'(w_tail_sum - (WA_W + 1)'(WINDOW_DEPTH)) : WA_W'(w_tail_sum);

    swrt_ram #(
        .WIDTH (TAG_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_qram (
        .clk   (clk),
        .we    (cmd.q_push),
        .waddr (q_tail),
        .wdata (tag_reg),
        .re    (cmd.q_rd),
        .raddr (q_head_reg),
        .rdata (q_rdata)
    );

    swrt_ram #(
        .WIDTH (WR_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_wram (
        .clk   (clk),
        .we    (cmd.w_push),
        .waddr (w_tail),
        .wdata ({now_reg, n_reg}),
        .re    (cmd.w_rd),
        .raddr (w_head_reg),
        .rdata (w_rdata)
    );

    // status
    assign sts.op       = op_reg;
    assign sts.enable   = enable_reg;
    assign sts.q_full   = (q_count_reg >= q_lim);
    assign sts.leak     = (swrt_pkg::THR_W'(rnd_reg) < leak_reg) && (q_count_reg != '0);
    assign sts.q_empty  = (q_count_reg == '0);
    assign sts.w_short  = (w_size_reg <= WS_W'(2));
    assign sts.w_full   = (w_size_reg == WS_W'(WINDOW_DEPTH));
    assign sts.w_over   = (w_size_reg > w_lim);
    assign sts.rel_ok   = ge_reg && (q_count_reg != '0) && (TW'(acc_reg) < elapsed_reg);
    assign sts.n_zero   = (n_reg == '0);
    assign sts.out_free = !out_valid || out_ready;

    // queue pointers
    always_comb
    begin
        q_head_next  = q_head_reg;
        q_count_next = q_count_reg;
        if (cmd.q_pop)
        begin
            q_head_next = (q_head_reg == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_reg + QA_W'(1);
        end
        case ({cmd.q_push, cmd.q_pop})
            2'b10:   q_count_next = q_count_reg + QC_W'(1);
            2'b01:   q_count_next = q_count_reg - QC_W'(1);
            default: q_count_next = q_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            period_reg  <= swrt_pkg::PERIOD_W'(1000);
            leak_reg    <= '0;
            qlimit_reg  <= swrt_pkg::QLIM_W'(32);
            idle_reg    <= swrt_pkg::PERIOD_W'(1000);
            wbatch_reg  <= swrt_pkg::WB_W'(1);
            wlimit_reg  <= swrt_pkg::WLIM_W'(16);
            q_head_reg  <= '0;
            q_count_reg <= '0;
            w_head_reg  <= '0;
            w_size_reg  <= '0;
            total_reg   <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    swrt_pkg::CFG_ENABLE: enable_reg <= cfg_data[0];
                    swrt_pkg::CFG_PERIOD: period_reg <= cfg_data;
                    swrt_pkg::CFG_LEAK:   leak_reg   <= cfg_data[swrt_pkg::THR_W-1:0];
                    swrt_pkg::CFG_QLIMIT: qlimit_reg <= cfg_data[swrt_pkg::QLIM_W-1:0];
                    swrt_pkg::CFG_IDLE:   idle_reg   <= cfg_data;
                    swrt_pkg::CFG_WBATCH: wbatch_reg <= cfg_data[swrt_pkg::WB_W-1:0];
                    swrt_pkg::CFG_WLIMIT: wlimit_reg <= cfg_data[swrt_pkg::WLIM_W-1:0];
                    default: ;
                endcase
            end
            q_head_reg  <= q_head_next;
            q_count_reg <= q_count_next;
            if (cmd.w_push)
            begin
                w_size_reg <= w_size_reg + WS_W'(1);
                total_reg  <= total_reg + TOT_W'(n_reg);
            end
            else if (cmd.w_pop)
            begin
                w_head_reg <= (w_head_reg == WA_W'(WINDOW_DEPTH - 1)) ? '0
                            : w_head_reg + WA_W'(1);
                w_size_reg <= w_size_reg - WS_W'(1);
                total_reg  <= total_reg - TOT_W'(w_rd_cnt);
            end
            if (cmd.emit)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= in_operation;
            tag_reg <= in_request_tag;
            now_reg <= in_now_us;
            rnd_reg <= in_random_value;
        end
        if (cmd.n_clear)
        begin
            n_reg <= '0;
        end
        else if (cmd.n_one)
        begin
            n_reg <= CW'(1);
        end
        else if (cmd.acc_step)
        begin
            n_reg <= n_reg + CW'(1);
        end
        if (cmd.acc_init)
        begin
            acc_reg <= (ACC_W'(total_reg) + ACC_W'(1)) * ACC_W'(period_reg);
        end
        else if (cmd.acc_step)
        begin
            acc_reg <= acc_reg + ACC_W'(period_reg);
        end
        if (cmd.latch_t0)
        begin
            elapsed_reg <= now_reg - w_rd_time;
            ge_reg      <= (now_reg >= w_rd_time);
        end
        if (cmd.exp_mul)
        begin
            exp_reg <= (EXP_W'(w_size_reg) + EXP_W'(wbatch_reg)) * EXP_W'(period_reg);
        end
        if (cmd.emit)
        begin
            out_kind           <= swrt_pkg::KIND_VERDICT;
            out_tag            <= '0;
            out_dropped        <= 1'b0;
            out_evicted        <= 1'b0;
            out_evicted_tag    <= '0;
            out_next_expire_us <= '0;
            out_last           <= cmd.last;
            case (cmd.emit_sel)
                swrt_pkg::EMIT_PASS:
                begin
                    out_kind <= swrt_pkg::KIND_RELEASE;
                    out_tag  <= tag_reg;
                end
                swrt_pkg::EMIT_VERDICT:
                begin
                    out_tag     <= tag_reg;
                    out_dropped <= sts.q_full;
                end
                swrt_pkg::EMIT_EVICT:
                begin
                    out_tag         <= tag_reg;
                    out_dropped     <= 1'b1;
                    out_evicted     <= 1'b1;
                    out_evicted_tag <= q_rdata;
                end
                swrt_pkg::EMIT_RELEASE:
                begin
                    out_kind <= swrt_pkg::KIND_RELEASE;
                    out_tag  <= q_rdata;
                end
                swrt_pkg::EMIT_IDLE:
                begin
                    out_kind           <= swrt_pkg::KIND_TIMER;
                    out_next_expire_us <= now_reg + TW'(idle_reg);
                end
                swrt_pkg::EMIT_EXPIRY:
                begin
                    out_kind           <= swrt_pkg::KIND_TIMER;
                    out_next_expire_us <= w_rd_time + TW'(exp_reg);
                end
                default: ;
            endcase
        end
    end

    a_qcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(q_count_reg) <= QUEUE_DEPTH)
        else $error("queue occupancy beyond depth");

    a_wsize_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(w_size_reg) <= WINDOW_DEPTH)
        else $error("window size beyond depth");

    a_qpop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_pop |-> q_count_reg != '0)
        else $error("pop from empty queue");

    a_wpop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.w_pop |-> w_size_reg != '0)
        else $error("pop from empty window");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_tag) && $stable(out_kind))
        else $error("pending result overwritten");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the sliding window request throttler
module testbench;

    localparam int QDEPTH     = swrt_pkg::QUEUE_DEPTH_DEF;
    localparam int WDEPTH     = swrt_pkg::WINDOW_DEPTH_DEF;
    localparam int TW         = swrt_pkg::TIME_W;
    localparam int KW         = swrt_pkg::KIND_W;
    localparam int RW         = swrt_pkg::RND_W;
    localparam int IW         = swrt_pkg::CFG_IDX_W;
    localparam int DW         = swrt_pkg::CFG_DATA_W;
    localparam int STALL_STOP = 4000;

    typedef struct packed {
        logic            op;
        logic [15:0]     tag;
        logic [TW-1:0]   now;
        logic [RW-1:0]   rnd;
    } event_t;

    typedef struct packed {
        logic [KW-1:0]   kind;
        logic [15:0]     tag;
        logic            dropped;
        logic            evicted;
        logic [15:0]     evicted_tag;
        logic [TW-1:0]   next_expire;
        logic            last;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IW-1:0] cfg_index;
    logic [DW-1:0] cfg_data;

    swrt_req_if req_ch ();
    swrt_res_if res_ch ();

    sliding_window_request_throttler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch.sink),
        .res       (res_ch.source)
    );

    // configuration mirror
    longint unsigned thr_enable, thr_period, thr_leak, thr_qlimit;
    longint unsigned thr_idle, thr_wbatch, thr_wlimit;

    // throttler state mirror
    logic [15:0]   held_tags [QDEPTH];
    int            held_head, held_count;
    logic [TW-1:0] win_times [WDEPTH];
    int            win_counts [WDEPTH];
    int            win_head, win_size;

    event_t   pending_events [$];
    outcome_t awaited_outcomes [$];
    event_t   shown_event;
    logic     calm;
    logic     drain_pause;
    int       errors;
    int       stall_cycles;
    logic [TW-1:0] clock_us;

    function automatic void expect_outcome(logic [KW-1:0] kind, logic [15:0] tag,
                                           logic drop, logic ev, logic [15:0] evtag,
                                           logic [TW-1:0] nxt);
        outcome_t o;
        o.kind = kind;
        o.tag = tag;
        o.dropped = drop;
        o.evicted = ev;
        o.evicted_tag = evtag;
        o.next_expire = nxt;
        o.last = 1'b0;
        awaited_outcomes.insert(awaited_outcomes.size(), o);
    endfunction

    function automatic logic [15:0] take_oldest();
        logic [15:0] t;
        t = held_tags[held_head];
        held_head = (held_head + 1) % QDEPTH;
        held_count--;
        return t;
    endfunction

    function automatic void hold_tag(logic [15:0] t);
        held_tags[(held_head + held_count) % QDEPTH] = t;
        held_count++;
    endfunction

    function automatic void drop_oldest_slot();
        win_head = (win_head + 1) % WDEPTH;
        win_size--;
    endfunction

    function automatic void record_release(logic [TW-1:0] t, int n);
        int i;
        if (win_size >= WDEPTH)
            drop_oldest_slot();
        i = (win_head + win_size) % WDEPTH;
        win_times[i] = t;
        win_counts[i] = n & 63;
        win_size++;
    endfunction

    function automatic void throttle_event(event_t e);
        longint unsigned lim, total, n, elapsed;
        logic [TW-1:0] t0, nxt;
        logic [15:0] old_tag;
        int i;
        if (e.op == swrt_pkg::OP_REQUEST)
        begin
            if (thr_enable == 0)
            begin
                expect_outcome(swrt_pkg::KIND_RELEASE, e.tag, 1'b0, 1'b0, '0, '0);
            end
            else
            begin
                lim = thr_qlimit;
                if (lim < 1) lim = 1;
                if (lim > QDEPTH) lim = QDEPTH;
                if (held_count >= lim)
                begin
                    if (e.rnd < thr_leak && held_count > 0)
                    begin
                        old_tag = take_oldest();
                        hold_tag(e.tag);
                        expect_outcome(swrt_pkg::KIND_VERDICT, e.tag, 1'b1, 1'b1, old_tag, '0);
                    end
                    else
                        expect_outcome(swrt_pkg::KIND_VERDICT, e.tag, 1'b1, 1'b0, '0, '0);
                end
                else
                begin
                    hold_tag(e.tag);
                    expect_outcome(swrt_pkg::KIND_VERDICT, e.tag, 1'b0, 1'b0, '0, '0);
                end
            end
        end
        else if (held_count == 0)
        begin
            expect_outcome(swrt_pkg::KIND_TIMER, '0, 1'b0, 1'b0, '0,
                           e.now + thr_idle[TW-1:0]);
        end
        else if (win_size <= 2)
        begin
            expect_outcome(swrt_pkg::KIND_RELEASE, take_oldest(), 1'b0, 1'b0, '0, '0);
            record_release(e.now, 1);
            expect_outcome(swrt_pkg::KIND_TIMER, '0, 1'b0, 1'b0, '0,
                           e.now + thr_idle[TW-1:0]);
        end
        else
        begin
            t0 = win_times[win_head];
            total = 0;
            n = 0;
            for (i = 0; i < win_size; i++)
                total += win_counts[(win_head + i) % WDEPTH];
            if (e.now >= t0)
            begin
                elapsed = {16'h0, e.now - t0};
                while (held_count > 0 && (total + n + 1) * thr_period < elapsed)
                begin
                    expect_outcome(swrt_pkg::KIND_RELEASE, take_oldest(), 1'b0, 1'b0,
                                   '0, '0);
                    n++;
                end
            end
            if (n > 0)
            begin
                record_release(e.now, int'(n));
                lim = thr_wlimit;
                if (lim < 1) lim = 1;
                if (lim > WDEPTH) lim = WDEPTH;
                while (win_size > lim)
                    drop_oldest_slot();
            end
            nxt = TW'(win_times[win_head] + (longint'(win_size) + thr_wbatch) * thr_period);
            expect_outcome(swrt_pkg::KIND_TIMER, '0, 1'b0, 1'b0, '0, nxt);
        end
        awaited_outcomes[$].last = 1'b1;
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = 1'b0;
        req_ch.request_tag = '0;
        req_ch.now_us = '0;
        req_ch.random_value = '0;
        res_ch.ready = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver
    always @(posedge clk)
    begin
        logic nv;
        event_t e;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                throttle_event(shown_event);
            nv = req_ch.valid && !req_ch.ready;
            if (!nv && pending_events.size() > 0
                && !(drain_pause && awaited_outcomes.size() > 0)
                && (calm || $urandom_range(99) >= 7))
            begin
                e = pending_events[0];
                pending_events.delete(0);
                shown_event = e;
                req_ch.operation <= e.op;
                req_ch.request_tag <= e.tag;
                req_ch.now_us <= e.now;
                req_ch.random_value <= e.rnd;
                nv = 1'b1;
            end
            req_ch.valid <= nv;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        outcome_t got, want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.kind = res_ch.kind;
                got.tag = res_ch.tag;
                got.dropped = res_ch.dropped;
                got.evicted = res_ch.evicted;
                got.evicted_tag = res_ch.evicted_tag;
                got.next_expire = res_ch.next_expire_us;
                got.last = res_ch.last;
                if (awaited_outcomes.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = awaited_outcomes[0];
                    awaited_outcomes.delete(0);
                    if (got !== want)
                    begin
                        $display("%0t mismatch: expected %p, actual %p", $time, want, got);
                        errors++;
                    end
                end
            end
            res_ch.ready <= calm || $urandom_range(99) >= 7;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles > STALL_STOP)
            begin
                $display("sliding_window_request_throttler verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [IW-1:0] idx, longint unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[DW-1:0];
        case (idx)
            swrt_pkg::CFG_ENABLE: thr_enable = val & 1;
            swrt_pkg::CFG_PERIOD: thr_period = val & 20'hFFFFF;
            swrt_pkg::CFG_LEAK:   thr_leak = val & 17'h1FFFF;
            swrt_pkg::CFG_QLIMIT: thr_qlimit = val & 63;
            swrt_pkg::CFG_IDLE:   thr_idle = val & 20'hFFFFF;
            swrt_pkg::CFG_WBATCH: thr_wbatch = val & 63;
            swrt_pkg::CFG_WLIMIT: thr_wlimit = val & 31;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(longint unsigned en, longint unsigned per, longint unsigned leak,
                           longint unsigned ql, longint unsigned idle, longint unsigned wb,
                           longint unsigned wl);
        write_reg(swrt_pkg::CFG_ENABLE, en);
        write_reg(swrt_pkg::CFG_PERIOD, per);
        write_reg(swrt_pkg::CFG_LEAK, leak);
        write_reg(swrt_pkg::CFG_QLIMIT, ql);
        write_reg(swrt_pkg::CFG_IDLE, idle);
        write_reg(swrt_pkg::CFG_WBATCH, wb);
        write_reg(swrt_pkg::CFG_WLIMIT, wl);
    endtask

    task automatic settle();
        do @(posedge clk);
        while (pending_events.size() > 0 || req_ch.valid || awaited_outcomes.size() > 0);
        repeat (150) @(posedge clk);
    endtask

    function automatic void add_event(logic op, logic [15:0] tag, logic [TW-1:0] now,
                                      logic [RW-1:0] rnd);
        event_t e;
        e.op = op;
        e.tag = tag;
        e.now = now;
        e.rnd = rnd;
        pending_events.insert(pending_events.size(), e);
    endfunction

    task automatic add_traffic(int count, int timer_pct);
        int k;
        logic [TW-1:0] t;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(19))
                0: clock_us = TW'({$urandom(), $urandom()});
                1: clock_us = clock_us - TW'($urandom_range(0, 5000));
                default: clock_us = clock_us + TW'($urandom_range(0, 32'(4 * thr_period + 4)));
            endcase
            t = clock_us;
            if ($urandom_range(99) < timer_pct)
                add_event(swrt_pkg::OP_TIMER, 16'($urandom()), t, RW'($urandom()));
            else
                add_event(swrt_pkg::OP_REQUEST, 16'($urandom()),
                          TW'({$urandom(), $urandom()}), RW'($urandom()));
        end
    endtask

    initial
    begin
        int ph;
        errors = 0;
        stall_cycles = 0;
        calm = 1'b0;
        drain_pause = 1'b0;
        held_head = 0;
        held_count = 0;
        win_head = 0;
        win_size = 0;
        thr_enable = 0;
        thr_period = 1000;
        thr_leak = 0;
        thr_qlimit = 32;
        thr_idle = 1000;
        thr_wbatch = 1;
        thr_wlimit = 16;
        clock_us = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: pass-through and timers on an empty queue, time wrap
        add_event(swrt_pkg::OP_REQUEST, 16'h0000, '0, '0);
        add_event(swrt_pkg::OP_REQUEST, 16'hFFFF, '1, '1);
        add_event(swrt_pkg::OP_TIMER, 16'h1234, '0, '0);
        add_event(swrt_pkg::OP_TIMER, 16'hFFFF, '1, 16'h5555);
        settle();

        // tight limits: full queue, eviction, short and long windows
        set_all(1, 1, 65536, 1, 1, 0, 3);
        add_event(swrt_pkg::OP_REQUEST, 16'h0001, '0, '0);
        add_event(swrt_pkg::OP_REQUEST, 16'h0002, '0, 16'h0000);
        add_event(swrt_pkg::OP_REQUEST, 16'h0003, '0, 16'hFFFF);
        add_event(swrt_pkg::OP_TIMER, 16'h0000, 48'd10, '0);
        add_event(swrt_pkg::OP_REQUEST, 16'h0004, '0, '0);
        add_event(swrt_pkg::OP_TIMER, 16'h0000, 48'd20, '0);
        add_event(swrt_pkg::OP_REQUEST, 16'h0005, '0, '0);
        add_event(swrt_pkg::OP_TIMER, 16'h0000, 48'd30, '0);
        add_event(swrt_pkg::OP_REQUEST, 16'h0006, '0, '0);
        add_event(swrt_pkg::OP_TIMER, 16'h0000, 48'd5, '0);
        add_event(swrt_pkg::OP_TIMER, 16'h0000, 48'd100, '0);
        add_event(swrt_pkg::OP_TIMER, 16'h0000, '1, '0);
        settle();
        set_all(1, 1, 0, 1, 1, 0, 3);
        add_event(swrt_pkg::OP_REQUEST, 16'h00AA, '0, '0);
        add_event(swrt_pkg::OP_REQUEST, 16'h00BB, '0, '0);
        settle();

        // slowest period and largest limits; sender waits out each result
        set_all(1, 1000000, 32768, 32, 1000000, 32, 16);
        drain_pause = 1'b1;
        add_traffic(20, 30);
        settle();
        drain_pause = 1'b0;

        // defaults but throttling on, no idling on either side
        set_all(1, 1000, 0, 32, 1000, 1, 16);
        calm = 1'b1;
        for (ph = 0; ph < 20; ph++)
            add_event(swrt_pkg::OP_REQUEST, 16'($urandom()), '0, RW'($urandom()));
        add_traffic(20, 35);
        settle();
        calm = 1'b0;

        for (ph = 0; ph < 3; ph++)
        begin
            set_all(1, $urandom_range(1, 200), $urandom_range(0, 65536),
                    $urandom_range(1, 32), $urandom_range(1, 1000000),
                    $urandom_range(0, 32), $urandom_range(3, 16));
            add_traffic(20, 40);
            settle();
        end

        // throttling off again, timers still processed
        set_all(0, 500, 65536, 4, 77, 2, 5);
        add_traffic(15, 50);
        settle();

        if (errors == 0)
            $display("sliding_window_request_throttler verification clean");
        else
            $display("sliding_window_request_throttler verification failed");
        $finish;
    end
endmodule
